/* rtl/core/ycc2rgb_pkg.sv */
// Shared types, widths and coefficient helpers for the YCbCr to RGBA converter.
package ycc2rgb_pkg;

  localparam int WORD_W      = 16;
  localparam int SAMPLE_W    = 10;
  localparam int CHROMA_W    = SAMPLE_W + 1;
  localparam int CHAN_W      = 8;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 2;
  localparam int P010_SHIFT  = 6;

  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam logic [CHROMA_W-1:0] OFFSET_8BIT = CHROMA_W'(128);
  localparam logic [CHROMA_W-1:0] OFFSET_P010 = CHROMA_W'(512);
  localparam logic [CHAN_W-1:0]   CHANNEL_MAX = 8'hFF;

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] REG_MODE_ADDR = '0;

  // Coefficients in millionths.
  localparam longint MICRO_CR_R = 1402000;
  localparam longint MICRO_CB_G = 344136;
  localparam longint MICRO_CR_G = 714136;
  localparam longint MICRO_CB_B = 1772000;

  typedef enum logic {
    FMT_8BIT = 1'b0,
    FMT_P010 = 1'b1
  } sample_fmt_e;

  // One decoded pixel: luma as an unsigned sample, chroma centered on zero.
  typedef struct packed {
    logic [SAMPLE_W-1:0]        y;
    logic signed [CHROMA_W-1:0] cb;
    logic signed [CHROMA_W-1:0] cr;
    sample_fmt_e                fmt;
  } ycc_sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_pixel_t;

  // Round-half-up fixed-point coefficient with the given fraction bits.
  function automatic longint coef_q(longint micro, int frac);
    return (micro * (longint'(1) << frac) + 500000) / 1000000;
  endfunction

endpackage

/* rtl/core/ycc2rgb_in_if.sv */
// Input pixel channel: valid/ready handshake carrying three sample words.
interface ycc2rgb_in_if;
  import ycc2rgb_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] luma_word;
  logic [WORD_W-1:0] cb_word;
  logic [WORD_W-1:0] cr_word;

  modport source (output valid, output luma_word, output cb_word, output cr_word,
                  input ready);
  modport sink   (input valid, input luma_word, input cb_word, input cr_word,
                  output ready);
endinterface

/* rtl/core/ycc2rgb_out_if.sv */
// Output pixel channel: valid/ready handshake carrying one RGBA pixel.
interface ycc2rgb_out_if;
  import ycc2rgb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

/* rtl/core/ycc2rgb_cfg.sv */
// APB-style register file holding the sample format mode.
module ycc2rgb_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ycc2rgb_pkg::ADDR_W-1:0] paddr,
  input  logic [ycc2rgb_pkg::DATA_W-1:0] pwdata,
  output logic [ycc2rgb_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output ycc2rgb_pkg::sample_fmt_e       fmt_o
);
  import ycc2rgb_pkg::*;

  sample_fmt_e fmt_q, fmt_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_MODE_ADDR);

  always_comb begin
    fmt_d = fmt_q;
    if (wr_en) begin
      fmt_d = sample_fmt_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_8BIT;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MODE_ADDR) begin
      prdata = {{(DATA_W-1){1'b0}}, fmt_q};
    end
  end

  assign fmt_o = fmt_q;
endmodule

/* rtl/core/ycc2rgb_matrix.sv */
// Fixed-point color matrix with truncation and saturation of each channel.
module ycc2rgb_matrix #(
  parameter int COEF_FRAC_BITS = ycc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  ycc2rgb_pkg::ycc_sample_t sample_i,
  output ycc2rgb_pkg::rgb_pixel_t  pixel_o
);
  import ycc2rgb_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 1;      // unsigned coefficient width
  localparam int PW = CW + 1 + CHROMA_W;       // signed product width
  localparam int AW = COEF_FRAC_BITS + 14;     // accumulator width

  localparam logic signed [CW:0] K_CR_R = {1'b0, CW'(coef_q(MICRO_CR_R, COEF_FRAC_BITS))};
  localparam logic signed [CW:0] K_CB_G = {1'b0, CW'(coef_q(MICRO_CB_G, COEF_FRAC_BITS))};
  localparam logic signed [CW:0] K_CR_G = {1'b0, CW'(coef_q(MICRO_CR_G, COEF_FRAC_BITS))};
  localparam logic signed [CW:0] K_CB_B = {1'b0, CW'(coef_q(MICRO_CB_B, COEF_FRAC_BITS))};

  logic signed [AW-1:0] base;
  logic signed [PW-1:0] p_cr_r, p_cb_g, p_cr_g, p_cb_b;
  logic signed [AW-1:0] acc_r, acc_g, acc_b;

  // Negative sums go to zero; P010 results drop two more bits to land in 0..255.
  function automatic logic [CHAN_W-1:0] saturate(logic signed [AW-1:0] acc,
                                                  sample_fmt_e fmt);
    logic signed [AW-1:0] sh;
    logic [CHAN_W-1:0]    res;
    sh = (fmt == FMT_P010) ? (acc >>> (COEF_FRAC_BITS + 2)) : (acc >>> COEF_FRAC_BITS);
    if (acc[AW-1]) begin
      res = '0;
    end else if (|sh[AW-1:CHAN_W]) begin
      res = CHANNEL_MAX;
    end else begin
      res = sh[CHAN_W-1:0];
    end
    return res;
  endfunction

  assign base   = $signed(AW'(sample_i.y) << COEF_FRAC_BITS);
  assign p_cr_r = K_CR_R * sample_i.cr;
  assign p_cb_g = K_CB_G * sample_i.cb;
  assign p_cr_g = K_CR_G * sample_i.cr;
  assign p_cb_b = K_CB_B * sample_i.cb;

  assign acc_r = base + AW'(p_cr_r);
  assign acc_g = base - AW'(p_cb_g) - AW'(p_cr_g);
  assign acc_b = base + AW'(p_cb_b);

  assign pixel_o.red   = saturate(acc_r, sample_i.fmt);
  assign pixel_o.green = saturate(acc_g, sample_i.fmt);
  assign pixel_o.blue  = saturate(acc_b, sample_i.fmt);
endmodule

/* rtl/core/ycbcr_to_rgba_pixel_converter.sv */
// Top level of the full-range BT.601 YCbCr to RGBA pixel converter.
//
// Pixels arrive on pix_in_i as three 16-bit sample words and leave on pix_out_o
// as an RGBA pixel with alpha fixed at 255. Both channels use valid/ready; a
// transfer happens on a clock edge where both are high.
// The mode register at byte address 0 selects 8-bit samples (bits 7:0, chroma
// offset 128) or P010 words (bits 15:6, chroma offset 512). It is written over
// the APB-style port and should only change while no pixels are in flight.
// The block is a two-register pipeline: the input register holds the decoded
// samples, the color matrix and saturation sit between it and the result
// register. An input transfer loads the input register, and the result register
// then drives valid on the output. One pixel is accepted every cycle while the
// receiver does not stall.
// When the receiver stalls, the result register holds its pixel and the input
// register fills; pix_in_i.ready drops only once both are occupied.
// Reset empties both pipeline registers and sets the mode to 8-bit.
module ycbcr_to_rgba_pixel_converter #(
  parameter int COEF_FRAC_BITS = ycc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ycc2rgb_in_if.sink                     pix_in_i,
  ycc2rgb_out_if.source                  pix_out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ycc2rgb_pkg::ADDR_W-1:0] paddr,
  input  logic [ycc2rgb_pkg::DATA_W-1:0] pwdata,
  output logic [ycc2rgb_pkg::DATA_W-1:0] prdata,
  output logic                           pready
);
  import ycc2rgb_pkg::*;

  sample_fmt_e fmt;
  ycc_sample_t dec_d, dec_q;
  rgb_pixel_t  pix_d, pix_q;
  logic        s1_v_q, s1_v_d;
  logic        out_v_q, out_v_d;
  logic        s1_ready, s2_ready;
  logic [SAMPLE_W-1:0] y_s, cb_s, cr_s;
  logic [CHROMA_W-1:0] offset;

  ycc2rgb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fmt_o   (fmt)
  );

  // Sample decode ahead of the input register.
  always_comb begin
    if (fmt == FMT_P010) begin
      y_s    = pix_in_i.luma_word[WORD_W-1:P010_SHIFT];
      cb_s   = pix_in_i.cb_word[WORD_W-1:P010_SHIFT];
      cr_s   = pix_in_i.cr_word[WORD_W-1:P010_SHIFT];
      offset = OFFSET_P010;
    end else begin
      y_s    = SAMPLE_W'(pix_in_i.luma_word[CHAN_W-1:0]);
      cb_s   = SAMPLE_W'(pix_in_i.cb_word[CHAN_W-1:0]);
      cr_s   = SAMPLE_W'(pix_in_i.cr_word[CHAN_W-1:0]);
      offset = OFFSET_8BIT;
    end
    dec_d.y   = y_s;
    dec_d.cb  = $signed({1'b0, cb_s} - offset);
    dec_d.cr  = $signed({1'b0, cr_s} - offset);
    dec_d.fmt = fmt;
  end

  ycc2rgb_matrix #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_matrix (
    .sample_i (dec_q),
    .pixel_o  (pix_d)
  );

  assign s2_ready       = !out_v_q || pix_out_o.ready;
  assign s1_ready       = !s1_v_q || s2_ready;
  assign pix_in_i.ready = s1_ready;

  assign s1_v_d  = s1_ready ? pix_in_i.valid : s1_v_q;
  assign out_v_d = s2_ready ? s1_v_q : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_in_i.valid && s1_ready) begin
      dec_q <= dec_d;
    end
    if (s1_v_q && s2_ready) begin
      pix_q <= pix_d;
    end
  end

  assign pix_out_o.valid = out_v_q;
  assign pix_out_o.red   = pix_q.red;
  assign pix_out_o.green = pix_q.green;
  assign pix_out_o.blue  = pix_q.blue;
  assign pix_out_o.alpha = CHANNEL_MAX;
endmodule
